FILE: rtl/core/sha256_hash_engine_macros.svh
// ---------------------------------------------------------------------------
// SHA-256 hash engine assertion macros
// Same-cycle and next-cycle implication checks, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef SHA256_HASH_ENGINE_MACROS_SVH
`define SHA256_HASH_ENGINE_MACROS_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define SHA_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define SHA_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/sha256_pkg.sv
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the hash engine.
// ---------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

   localparam int BLOCK_COUNT_WIDTH_DEF = 32;
   localparam int BLK_FIFO_DEPTH        = 2;
   localparam int NUM_ROUNDS            = 64;
   localparam logic [31:0] PAD_WORD     = 32'h8000_0000;

   typedef struct packed {
      logic [15:0][31:0] words;
      logic              fin;
   } blk_type;

   typedef struct packed {
      logic [7:0][31:0] words;
      logic             valid;
   } digest_type;

   typedef enum logic [1:0] {FR_COLLECT, FR_PAD1, FR_PAD2} front_state_type;
   typedef enum logic [1:0] {CR_IDLE, CR_ROUND, CR_ADD} core_state_type;

   function automatic logic [31:0] init_chain(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0:    r = 32'h6a09e667;
         3'd1:    r = 32'hbb67ae85;
         3'd2:    r = 32'h3c6ef372;
         3'd3:    r = 32'ha54ff53a;
         3'd4:    r = 32'h510e527f;
         3'd5:    r = 32'h9b05688c;
         3'd6:    r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [63:0][31:0] k;
      k = {32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
           32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
           32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
           32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
           32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
           32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
           32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
           32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
           32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
           32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
           32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
           32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
           32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
           32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
           32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
           32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98};
      return k[i];
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function automatic logic [31:0] big_sig0(input logic [31:0] x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic logic [31:0] big_sig1(input logic [31:0] x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic logic [31:0] small_sig0(input logic [31:0] x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic logic [31:0] small_sig1(input logic [31:0] x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

endpackage
`default_nettype wire

FILE: rtl/core/sha256_front.sv
// ---------------------------------------------------------------------------
// SHA-256 front end
// Collects message words into blocks and builds the padded final block(s).
// ---------------------------------------------------------------------------
`default_nettype none
module sha256_front #(
   parameter int BLOCK_COUNT_WIDTH = sha256_pkg::BLOCK_COUNT_WIDTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [31:0]       msg_word,
   input  wire logic [2:0]        byte_count,
   input  wire logic              last_word,
   output logic                   full,
   input  wire logic              q_full,
   output logic                   q_push,
   output sha256_pkg::blk_type    q_data
);

   sha256_pkg::front_state_type state_ff, state_in;
   logic [15:0][31:0] buf_ff, buf_in;
   logic [3:0]        idx_ff, idx_in;
   logic [BLOCK_COUNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [63:0]       len_ff, len_in;
   logic              two_ff, two_in;
   logic              carry_ff, carry_in;
   logic              accept;
   logic [2:0]        nb;
   logic [31:0]       keep, pad, last_val;

   always_comb begin
      nb = (byte_count > 3'd4) ? 3'd4 : byte_count;
      case (nb)
         3'd0:    begin keep = 32'h0000_0000; pad = 32'h8000_0000; end
         3'd1:    begin keep = 32'hFF00_0000; pad = 32'h0080_0000; end
         3'd2:    begin keep = 32'hFFFF_0000; pad = 32'h0000_8000; end
         3'd3:    begin keep = 32'hFFFF_FF00; pad = 32'h0000_0080; end
         default: begin keep = 32'hFFFF_FFFF; pad = 32'h0000_0000; end
      endcase
      last_val = (msg_word & keep) | pad;
   end

   assign full   = (state_ff != sha256_pkg::FR_COLLECT) || q_full;
   assign accept = push && !full;

   always_comb begin
      state_in = state_ff;
      buf_in   = buf_ff;
      idx_in   = idx_ff;
      cnt_in   = cnt_ff;
      len_in   = len_ff;
      two_in   = two_ff;
      carry_in = carry_ff;
      q_push   = 1'b0;
      q_data   = '0;
      unique case (state_ff)
         sha256_pkg::FR_COLLECT: begin
            q_data.words         = buf_ff;
            q_data.words[idx_ff] = msg_word;
            if (accept && !last_word) begin
               buf_in[idx_ff] = msg_word;
               idx_in         = idx_ff + 4'd1;
               if (idx_ff == 4'd15) begin
                  q_push = 1'b1;
                  cnt_in = cnt_ff + 1'b1;
               end
            end else if (accept) begin
               len_in = (64'(cnt_ff) << 9) + 64'({idx_ff, 5'b0}) + 64'({nb, 3'b0});
               for (int j = 0; j < 16; j++) begin
                  if (4'(j) == idx_ff) begin
                     buf_in[j] = last_val;
                  end else if (4'(j) > idx_ff) begin
                     buf_in[j] = (nb == 3'd4 && 4'(j) == idx_ff + 4'd1) ?
                                 sha256_pkg::PAD_WORD : 32'h0;
                  end
               end
               two_in   = (nb == 3'd4) ? (idx_ff >= 4'd13) : (idx_ff >= 4'd14);
               carry_in = (nb == 3'd4) && (idx_ff == 4'd15);
               state_in = sha256_pkg::FR_PAD1;
            end
         end
         sha256_pkg::FR_PAD1: begin
            q_data.words = buf_ff;
            q_data.fin   = !two_ff;
            if (!two_ff) begin
               q_data.words[14] = len_ff[63:32];
               q_data.words[15] = len_ff[31:0];
            end
            if (!q_full) begin
               q_push = 1'b1;
               if (two_ff) begin
                  state_in = sha256_pkg::FR_PAD2;
               end else begin
                  state_in = sha256_pkg::FR_COLLECT;
                  idx_in   = '0;
                  cnt_in   = '0;
               end
            end
         end
         sha256_pkg::FR_PAD2: begin
            q_data.words[0]  = carry_ff ? sha256_pkg::PAD_WORD : 32'h0;
            q_data.words[14] = len_ff[63:32];
            q_data.words[15] = len_ff[31:0];
            q_data.fin       = 1'b1;
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = sha256_pkg::FR_COLLECT;
               idx_in   = '0;
               cnt_in   = '0;
            end
         end
         default: state_in = sha256_pkg::FR_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::FR_COLLECT;
         idx_ff   <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff   <= buf_in;
      len_ff   <= len_in;
      two_ff   <= two_in;
      carry_ff <= carry_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_blk_fifo.sv
// ---------------------------------------------------------------------------
// SHA-256 block queue
// Short queue of padded blocks between the front end and the round core.
// ---------------------------------------------------------------------------
`default_nettype none
module sha256_blk_fifo (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_en,
   input  wire sha256_pkg::blk_type wr_data,
   output logic                     full,
   input  wire logic                rd_en,
   output sha256_pkg::blk_type      rd_data,
   output logic                     empty
);

   localparam int PW = (sha256_pkg::BLK_FIFO_DEPTH > 1) ?
                       $clog2(sha256_pkg::BLK_FIFO_DEPTH) : 1;
   localparam int CW = $clog2(sha256_pkg::BLK_FIFO_DEPTH + 1);

   sha256_pkg::blk_type mem_ff [sha256_pkg::BLK_FIFO_DEPTH];
   logic [PW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   assign full    = (cnt_ff == CW'(sha256_pkg::BLK_FIFO_DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_wr) begin
         wp_in = (wp_ff == PW'(sha256_pkg::BLK_FIFO_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_rd) begin
         rp_in = (rp_ff == PW'(sha256_pkg::BLK_FIFO_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wp_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_core.sv
// ---------------------------------------------------------------------------
// SHA-256 round core
// One compression round per cycle over a 16-word schedule window.
// ---------------------------------------------------------------------------
`default_nettype none
module sha256_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                q_empty,
   input  wire sha256_pkg::blk_type q_data,
   output logic                     q_pop,
   input  wire logic                out_busy,
   output sha256_pkg::digest_type   digest
);

   sha256_pkg::core_state_type state_ff, state_in;
   logic [5:0]        rnd_ff, rnd_in;
   logic [7:0][31:0]  v_ff, v_in, ch_ff, ch_in, sum;
   logic [15:0][31:0] w_ff, w_in;
   logic              fin_ff, fin_in;
   logic [31:0]       t1, t2, w_new;

   always_comb begin
      t1 = v_ff[7] + sha256_pkg::big_sig1(v_ff[4])
         + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
         + sha256_pkg::round_k(rnd_ff) + w_ff[0];
      t2 = sha256_pkg::big_sig0(v_ff[0])
         + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
      w_new = sha256_pkg::small_sig1(w_ff[14]) + w_ff[9]
            + sha256_pkg::small_sig0(w_ff[1]) + w_ff[0];
      for (int i = 0; i < 8; i++) begin
         sum[i] = ch_ff[i] + v_ff[i];
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      v_in     = v_ff;
      w_in     = w_ff;
      ch_in    = ch_ff;
      fin_in   = fin_ff;
      q_pop    = 1'b0;
      digest   = '0;
      unique case (state_ff)
         sha256_pkg::CR_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               w_in     = q_data.words;
               fin_in   = q_data.fin;
               v_in     = ch_ff;
               rnd_in   = '0;
               state_in = sha256_pkg::CR_ROUND;
            end
         end
         sha256_pkg::CR_ROUND: begin
            v_in = {v_ff[6:4], v_ff[3] + t1, v_ff[2:0], t1 + t2};
            w_in = {w_new, w_ff[15:1]};
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'(sha256_pkg::NUM_ROUNDS - 1)) begin
               state_in = sha256_pkg::CR_ADD;
            end
         end
         sha256_pkg::CR_ADD: begin
            if (!fin_ff) begin
               ch_in    = sum;
               state_in = sha256_pkg::CR_IDLE;
            end else if (!out_busy) begin
               // hand over the digest and restart the chain
               digest.words = sum;
               digest.valid = 1'b1;
               for (int i = 0; i < 8; i++) begin
                  ch_in[i] = sha256_pkg::init_chain(3'(i));
               end
               state_in = sha256_pkg::CR_IDLE;
            end
         end
         default: state_in = sha256_pkg::CR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256_pkg::CR_IDLE;
         for (int i = 0; i < 8; i++) begin
            ch_ff[i] <= sha256_pkg::init_chain(3'(i));
         end
      end else begin
         state_ff <= state_in;
         ch_ff    <= ch_in;
      end
   end

   always_ff @(posedge clock) begin
      rnd_ff <= rnd_in;
      v_ff   <= v_in;
      w_ff   <= w_in;
      fin_ff <= fin_in;
   end

endmodule
`default_nettype wire

FILE: rtl/core/sha256_hash_engine.sv
// Block flow: the round core loads a block, runs 64 rounds and adds it into the chain;
// the digest is handed out in the add step of the final block, once the output is free.
// Blocks: the core takes a new block only after the add step of the last one, so the
// block rate is set by the single shared round unit.
// Reset: synchronous, active high; clears the FSMs and restores the initial chain.
// ---------------------------------------------------------------------------
// SHA-256 hash engine top level
// Front end packs and pads words, a two-block queue feeds the round core,
// and an output stage hands the eight digest words out one beat at a time.
// ---------------------------------------------------------------------------
`default_nettype none
`include "sha256_hash_engine_macros.svh"
module sha256_hash_engine #(
   parameter int BLOCK_COUNT_WIDTH = sha256_pkg::BLOCK_COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [31:0] req_msg_word,
   input  wire logic [2:0]  req_byte_count,
   input  wire logic        req_last_word,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [31:0]      rsp_digest_word,
   output logic [2:0]       rsp_digest_index,
   output logic             rsp_digest_last
);

   sha256_pkg::blk_type    fr_blk, q_blk;
   sha256_pkg::digest_type digest;
   logic q_push, q_full, q_pop, q_empty;

   // front end: collect words, build padded blocks
   sha256_front #(.BLOCK_COUNT_WIDTH(BLOCK_COUNT_WIDTH)) u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (req_push),
      .msg_word   (req_msg_word),
      .byte_count (req_byte_count),
      .last_word  (req_last_word),
      .full       (req_full),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (fr_blk)
   );

   // decouple the front end from the round core
   sha256_blk_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_data (fr_blk),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_data (q_blk),
      .empty   (q_empty)
   );

   logic [7:0][31:0] dig_ff;
   logic [2:0]       idx_ff;
   logic             val_ff;

   // round core: one round per cycle
   sha256_core u_core (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_data   (q_blk),
      .q_pop    (q_pop),
      .out_busy (val_ff),
      .digest   (digest)
   );

   // output stage: hold the digest, advance one word per popped beat
   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff <= 1'b0;
         idx_ff <= '0;
      end else if (digest.valid) begin
         val_ff <= 1'b1;
         idx_ff <= '0;
      end else if (rsp_pop && val_ff) begin
         if (idx_ff == 3'd7) begin
            val_ff <= 1'b0;
         end
         idx_ff <= idx_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (digest.valid) begin
         dig_ff <= digest.words;
      end
   end

   assign rsp_empty        = !val_ff;
   assign rsp_digest_word  = dig_ff[idx_ff];
   assign rsp_digest_index = idx_ff;
   assign rsp_digest_last  = (idx_ff == 3'd7);

   `SHA_ASSERT_NOW(a_no_load_busy, clock, reset, digest.valid, !val_ff)
   `SHA_ASSERT_NEXT(a_last_drains, clock, reset, rsp_pop && !rsp_empty && rsp_digest_last, rsp_empty)
   `SHA_ASSERT_NEXT(a_idx_step, clock, reset, rsp_pop && !rsp_empty && !rsp_digest_last, !rsp_empty && rsp_digest_index == $past(rsp_digest_index) + 3'd1)

endmodule
`default_nettype wire
